[rtl/clp_pkg.sv]
// Shared types and constants for the command link frame parser.
package clp_pkg;

    localparam int DEBUG_FRAME_LEN   = 12;
    localparam int WEATHER_FRAME_LEN = 8;
    localparam int LINE_LIMIT        = 63;
    localparam int BURST_LEN         = 12;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] BYTE_SYNC_A  = 8'hAA;
    localparam logic [7:0] BYTE_SYNC_B  = 8'h55;
    localparam logic [7:0] BYTE_DEBUG   = 8'h01;
    localparam logic [7:0] CMD_WEATHER  = 8'h71;
    localparam logic [7:0] CMD_SPEED    = 8'h38;
    localparam logic [7:0] CMD_SWING    = 8'h39;
    localparam logic [7:0] CMD_ACTIVE   = 8'h60;
    localparam logic [7:0] CMD_QUIET    = 8'h61;
    localparam logic [7:0] CMD_SAVE     = 8'h62;
    localparam logic [7:0] CMD_ACT_0    = 8'h29;
    localparam logic [7:0] CMD_ACT_1    = 8'h30;
    localparam logic [7:0] CMD_ACT_2    = 8'h31;
    localparam logic [7:0] CMD_ACT_3    = 8'h32;
    localparam logic [7:0] CMD_ACT_4    = 8'h33;
    localparam logic [7:0] CMD_ACT_5    = 8'h34;
    localparam logic [7:0] CMD_ACT_6    = 8'h35;
    localparam logic [7:0] CMD_ACT_7    = 8'h36;
    localparam logic [7:0] CMD_ACT_8    = 8'h37;
    localparam logic [7:0] CMD_TAIL     = 8'h40;
    localparam logic [7:0] CMD_ACT_10   = 8'h41;
    localparam logic [7:0] CMD_ACT_11   = 8'h42;
    localparam logic [7:0] CMD_ACT_13   = 8'h43;
    localparam logic [7:0] CMD_ACT_14   = 8'h48;
    localparam logic [7:0] CMD_ACT_15   = 8'h49;
    localparam logic [7:0] CMD_DISPLAY  = 8'h70;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] SPEED_MAX    = 8'd200;
    localparam logic [7:0] SPEED_MIN    = 8'd120;
    localparam logic [7:0] SPEED_FLOOR  = 8'd100;
    localparam logic [7:0] SPEED_STEP   = 8'd20;
    localparam logic [3:0] SWING_MAX    = 4'd9;
    localparam logic [3:0] SWING_MIN    = 4'd4;
    localparam logic [3:0] SWING_FLOOR  = 4'd3;

    localparam logic [1:0] CHAN_ECHO  = 2'd0;
    localparam logic [1:0] CHAN_VOICE = 2'd1;
    localparam logic [1:0] CHAN_NONE  = 2'd2;

    localparam logic [1:0] WREQ_NONE   = 2'd0;
    localparam logic [1:0] WREQ_ACTIVE = 2'd1;
    localparam logic [1:0] WREQ_QUIET  = 2'd2;
    localparam logic [1:0] WREQ_SAVE   = 2'd3;

    typedef enum logic [1:0] {
        KIND_SILENT = 2'd0,
        KIND_ECHO   = 2'd1,
        KIND_BURST  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]  face_sel;
        logic [3:0]  motion_sel;
        logic [7:0]  speed_delay;
        logic [3:0]  swing_delay;
        logic [4:0]  flags;
        logic [1:0]  work_mode_request;
        logic [1:0]  events;
        logic [47:0] weather_record;
    } status_t;

    typedef struct packed {
        kind_t                    kind;
        logic [BURST_LEN-1:0][7:0] bytes;
        status_t                  status;
    } job_t;

endpackage

[rtl/clp_front.sv]
// Front end: frame tracking, command decode and job building for each byte.
module clp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output clp_pkg::job_t       job
);

    logic        debug_active_reg, debug_active_next;
    logic [3:0]  debug_count_reg, debug_count_next;
    logic [clp_pkg::DEBUG_FRAME_LEN-1:0][7:0] debug_frame_reg, debug_frame_next;
    logic        weather_active_reg, weather_active_next;
    logic [2:0]  weather_count_reg, weather_count_next;
    logic [clp_pkg::WEATHER_FRAME_LEN-1:0][7:0] weather_frame_reg, weather_frame_next;
    logic [47:0] weather_reg, weather_next;
    logic [2:0]  face_reg, face_next;
    logic [3:0]  action_reg, action_next;
    logic [7:0]  speed_reg, speed_next;
    logic [3:0]  swing_reg, swing_next;
    logic [3:0]  mode_reg, mode_next;
    logic [5:0]  line_count_reg, line_count_next;
    logic        line_ready_reg, line_ready_next;

    always_comb
    begin
        logic [1:0] wreq;
        logic [1:0] ev;
        logic [3:0] dcnt;
        logic [3:0] wcnt;
        debug_active_next   = debug_active_reg;
        debug_count_next    = debug_count_reg;
        debug_frame_next    = debug_frame_reg;
        weather_active_next = weather_active_reg;
        weather_count_next  = weather_count_reg;
        weather_frame_next  = weather_frame_reg;
        weather_next        = weather_reg;
        face_next           = face_reg;
        action_next         = action_reg;
        speed_next          = speed_reg;
        swing_next          = swing_reg;
        mode_next           = mode_reg;
        line_count_next     = line_count_reg;
        line_ready_next     = line_ready_reg;
        wreq = clp_pkg::WREQ_NONE;
        ev   = 2'b00;
        dcnt = debug_count_reg + 4'd1;
        wcnt = {1'b0, weather_count_reg} + 4'd1;
        job.kind  = clp_pkg::KIND_SILENT;
        job.bytes = '0;
        if (debug_active_reg)
        begin
            debug_frame_next[debug_count_reg] = rx_byte;
            debug_count_next = dcnt;
            if (dcnt == 4'd2)
            begin
                if (rx_byte != clp_pkg::BYTE_SYNC_B)
                begin
                    weather_active_next   = 1'b1;
                    weather_frame_next[0] = rx_byte;
                    weather_count_next    = 3'd1;
                    debug_active_next     = 1'b0;
                end
            end
            else if (dcnt == 4'(clp_pkg::DEBUG_FRAME_LEN))
            begin
                if (debug_frame_next[0] == clp_pkg::BYTE_SYNC_A &&
                    debug_frame_next[1] == clp_pkg::BYTE_SYNC_B &&
                    debug_frame_next[2] == clp_pkg::BYTE_DEBUG &&
                    debug_frame_next[clp_pkg::DEBUG_FRAME_LEN-2] == clp_pkg::BYTE_SYNC_B &&
                    debug_frame_next[clp_pkg::DEBUG_FRAME_LEN-1] == clp_pkg::BYTE_SYNC_A)
                begin
                    job.kind = clp_pkg::KIND_BURST;
                    for (int k = 0; k < clp_pkg::BURST_LEN; k++)
                        job.bytes[k] = debug_frame_next[k];
                end
                debug_active_next = 1'b0;
                debug_count_next  = 4'd0;
            end
        end
        else if (rx_byte == clp_pkg::BYTE_SYNC_A)
        begin
            debug_active_next  = 1'b1;
            debug_frame_next[0] = rx_byte;
            debug_count_next   = 4'd1;
        end
        else if (weather_active_reg)
        begin
            weather_frame_next[weather_count_reg] = rx_byte;
            weather_count_next = wcnt[2:0];
            if (wcnt == 4'(clp_pkg::WEATHER_FRAME_LEN))
            begin
                if (rx_byte == clp_pkg::BYTE_SYNC_B)
                begin
                    for (int k = 0; k < 6; k++)
                        weather_next[8*k +: 8] = weather_frame_next[k];
                    mode_next[2] = 1'b1;
                    ev[0] = 1'b1;
                    job.kind = clp_pkg::KIND_BURST;
                    job.bytes[0]  = clp_pkg::BYTE_SYNC_A;
                    job.bytes[1]  = clp_pkg::BYTE_SYNC_B;
                    job.bytes[2]  = clp_pkg::BYTE_DEBUG;
                    job.bytes[3]  = weather_frame_next[0];
                    job.bytes[4]  = weather_frame_next[1];
                    job.bytes[5]  = weather_frame_next[2];
                    job.bytes[6]  = weather_frame_next[4];
                    job.bytes[7]  = weather_frame_next[5];
                    job.bytes[8]  = 8'h00;
                    job.bytes[9]  = 8'h00;
                    job.bytes[10] = clp_pkg::BYTE_SYNC_B;
                    job.bytes[11] = clp_pkg::BYTE_SYNC_A;
                end
                weather_active_next = 1'b0;
                weather_count_next  = 3'd0;
            end
        end
        else
        begin
            job.kind     = clp_pkg::KIND_ECHO;
            job.bytes[0] = rx_byte;
            mode_next[3] = 1'b1;
            if (rx_byte == clp_pkg::CMD_WEATHER)
            begin
                mode_next[2] = ~mode_reg[2];
                ev[0] = ~mode_reg[2];
            end
            else
            begin
                mode_next[2] = 1'b0;
                case (rx_byte)
                    clp_pkg::CMD_ACT_0: begin face_next = 3'd0; action_next = 4'd0; end
                    clp_pkg::CMD_ACT_1: begin face_next = 3'd5; action_next = 4'd1; end
                    clp_pkg::CMD_ACT_2: begin face_next = 3'd2; action_next = 4'd2; end
                    clp_pkg::CMD_ACT_3: action_next = 4'd3;
                    clp_pkg::CMD_ACT_4: begin face_next = 3'd4; action_next = 4'd4; end
                    clp_pkg::CMD_ACT_5: begin face_next = 3'd1; action_next = 4'd5; end
                    clp_pkg::CMD_ACT_6: action_next = 4'd6;
                    clp_pkg::CMD_ACT_7: action_next = 4'd7;
                    clp_pkg::CMD_ACT_8: action_next = 4'd8;
                    clp_pkg::CMD_SPEED:
                    begin
                        if (speed_reg == clp_pkg::SPEED_MIN)
                            speed_next = clp_pkg::SPEED_MAX;
                        else if (speed_reg > clp_pkg::SPEED_FLOOR)
                            speed_next = speed_reg - clp_pkg::SPEED_STEP;
                        else
                            speed_next = clp_pkg::SPEED_MAX;
                    end
                    clp_pkg::CMD_SWING:
                    begin
                        if (swing_reg == clp_pkg::SWING_MIN)
                            swing_next = clp_pkg::SWING_MAX;
                        else if (swing_reg > clp_pkg::SWING_FLOOR)
                            swing_next = swing_reg - 4'd1;
                        else
                            swing_next = clp_pkg::SWING_MAX;
                    end
                    clp_pkg::CMD_TAIL:
                    begin
                        face_next = 3'd4;
                        mode_next[0] = ~mode_reg[0];
                    end
                    clp_pkg::CMD_ACT_10: action_next = 4'd10;
                    clp_pkg::CMD_ACT_11: action_next = 4'd11;
                    clp_pkg::CMD_ACT_13: begin face_next = 3'd6; action_next = 4'd13; end
                    clp_pkg::CMD_ACT_14: begin face_next = 3'd1; action_next = 4'd14; end
                    clp_pkg::CMD_ACT_15: action_next = 4'd15;
                    clp_pkg::CMD_DISPLAY: mode_next[1] = ~mode_reg[1];
                    clp_pkg::CMD_ACTIVE: wreq = clp_pkg::WREQ_ACTIVE;
                    clp_pkg::CMD_QUIET:  wreq = clp_pkg::WREQ_QUIET;
                    clp_pkg::CMD_SAVE:   wreq = clp_pkg::WREQ_SAVE;
                    default: ;
                endcase
            end
            ev[1] = 1'b1;
            if (line_count_reg < 6'(clp_pkg::LINE_LIMIT))
            begin
                line_count_next = line_count_reg + 6'd1;
                if (rx_byte == clp_pkg::CHAR_LF || rx_byte == clp_pkg::CHAR_CR)
                    line_ready_next = 1'b1;
            end
        end
        job.status.face_sel          = face_next;
        job.status.motion_sel        = action_next;
        job.status.speed_delay       = speed_next;
        job.status.swing_delay       = swing_next;
        job.status.flags             = {line_ready_next, mode_next};
        job.status.work_mode_request = wreq;
        job.status.events            = ev;
        job.status.weather_record    = weather_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debug_active_reg   <= 1'b0;
            debug_count_reg    <= 4'd0;
            weather_active_reg <= 1'b0;
            weather_count_reg  <= 3'd0;
            weather_reg        <= '0;
            face_reg           <= 3'd0;
            action_reg         <= 4'd0;
            speed_reg          <= clp_pkg::SPEED_MAX;
            swing_reg          <= clp_pkg::SWING_MAX;
            mode_reg           <= 4'd0;
            line_count_reg     <= 6'd0;
            line_ready_reg     <= 1'b0;
        end
        else if (accept)
        begin
            debug_active_reg   <= debug_active_next;
            debug_count_reg    <= debug_count_next;
            weather_active_reg <= weather_active_next;
            weather_count_reg  <= weather_count_next;
            weather_reg        <= weather_next;
            face_reg           <= face_next;
            action_reg         <= action_next;
            speed_reg          <= speed_next;
            swing_reg          <= swing_next;
            mode_reg           <= mode_next;
            line_count_reg     <= line_count_next;
            line_ready_reg     <= line_ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            debug_frame_reg   <= debug_frame_next;
            weather_frame_reg <= weather_frame_next;
        end
    end

endmodule

[rtl/clp_queue.sv]
// Two-entry job queue between front and back ends.
module clp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  clp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output clp_pkg::job_t head_job
);

    clp_pkg::job_t entry_reg [clp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(clp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(clp_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

[rtl/clp_back.sv]
// Back end: expands a queued job into output beats through an output register.
module clp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  clp_pkg::job_t  head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     tx_channel,
    output logic [7:0]     tx_byte,
    output logic           last,
    output clp_pkg::status_t status
);

    logic       valid_reg, valid_next;
    logic [3:0] idx_reg, idx_next;
    logic       load, idx_last;
    logic [1:0] chan_next;
    logic [7:0] byte_next;
    logic [1:0] chan_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    clp_pkg::status_t status_reg;

    assign load     = head_valid && (!valid_reg || out_ready);
    assign idx_last = (head_job.kind != clp_pkg::KIND_BURST) ||
                      (idx_reg == 4'(clp_pkg::BURST_LEN - 1));
    assign pop      = load && idx_last;
    assign idx_next = pop ? 4'd0 : (load ? idx_reg + 4'd1 : idx_reg);
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_comb
    begin
        case (head_job.kind)
            clp_pkg::KIND_ECHO:
            begin
                chan_next = clp_pkg::CHAN_ECHO;
                byte_next = head_job.bytes[0];
            end
            clp_pkg::KIND_BURST:
            begin
                chan_next = clp_pkg::CHAN_VOICE;
                byte_next = head_job.bytes[idx_reg];
            end
            default:
            begin
                chan_next = clp_pkg::CHAN_NONE;
                byte_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg   <= chan_next;
            byte_reg   <= byte_next;
            last_reg   <= idx_last;
            status_reg <= head_job.status;
        end
    end

    assign out_valid  = valid_reg;
    assign tx_channel = chan_reg;
    assign tx_byte    = byte_reg;
    assign last       = last_reg;
    assign status     = status_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < 4'(clp_pkg::BURST_LEN))
        else $error("beat index out of range");
    a_idx_only_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 4'd0) |-> (head_valid && head_job.kind == clp_pkg::KIND_BURST))
        else $error("beat index set without a burst at head");
    a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last))
        else $error("job retired without a last beat");

endmodule

[rtl/command_link_frame_parser.sv]
// Top level of the command link frame parser.
// Input channel: in_valid / in_ready with rx_byte, one received byte per beat.
// Output channel: out_valid / out_ready with tx_channel, tx_byte, last and the
// status fields (modes, delays, flags, work mode request, events, weather record).
// Each input byte yields one output beat, or twelve voice-link beats for a
// forwarded debug frame or a weather report; last marks the final beat.
// The front end decodes a byte in the cycle it is accepted and pushes a job
// into a two-entry queue; the back end drains one beat per cycle, while
// out_ready is high, through an output register. A job passes the queue entry
// and then the output register before out_valid rises. While out_ready is high,
// single-beat bytes go one per cycle and a burst goes one beat per cycle.
// in_ready drops only when the queue holds two jobs; a stalled receiver fills
// the queue and then holds off input without losing beats.
// Reset clears frame tracking, modes, counters and the queue; speed delay
// starts at 200 and swing delay at 9.
module command_link_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  tx_channel,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [2:0]  face_sel,
    output logic [3:0]  motion_sel,
    output logic [7:0]  speed_delay,
    output logic [3:0]  swing_delay,
    output logic [4:0]  flags,
    output logic [1:0]  work_mode_request,
    output logic [1:0]  events,
    output logic [47:0] weather_record
);

    logic             accept, full, pop, head_valid;
    clp_pkg::job_t    job, head_job;
    clp_pkg::status_t status;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    clp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .job     (job)
    );

    clp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_channel (tx_channel),
        .tx_byte    (tx_byte),
        .last       (last),
        .status     (status)
    );

    assign face_sel          = status.face_sel;
    assign motion_sel        = status.motion_sel;
    assign speed_delay       = status.speed_delay;
    assign swing_delay       = status.swing_delay;
    assign flags             = status.flags;
    assign work_mode_request = status.work_mode_request;
    assign events            = status.events;
    assign weather_record    = status.weather_record;

endmodule

[tb/tb_command_link_frame_parser.sv]
// Testbench for the command link frame parser: random and directed bytes against a predictor.
`timescale 1ns / 1ps

module tb_command_link_frame_parser;

    typedef struct {
        logic [1:0]  chan;
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  face;
        logic [3:0]  action;
        logic [7:0]  speed;
        logic [3:0]  swing;
        logic [4:0]  flg;
        logic [1:0]  wreq;
        logic [1:0]  ev;
        logic [47:0] wx;
    } beat_t;

    class frame_scoreboard;
        beat_t       pending[$];
        int          errors;
        bit          dbg_on;
        int          dbg_cnt;
        logic [7:0]  dbg_buf[clp_pkg::DEBUG_FRAME_LEN];
        bit          wx_on;
        int          wx_cnt;
        logic [7:0]  wx_buf[clp_pkg::WEATHER_FRAME_LEN];
        logic [47:0] wx_latch;
        logic [2:0]  face;
        logic [3:0]  action;
        logic [7:0]  speed;
        logic [3:0]  swing;
        logic [3:0]  mbits;
        int          line_cnt;
        bit          line_rdy;

        function new();
            errors = 0; dbg_on = 0; dbg_cnt = 0; wx_on = 0; wx_cnt = 0;
            wx_latch = '0; face = 0; action = 0; speed = clp_pkg::SPEED_MAX;
            swing = clp_pkg::SWING_MAX; mbits = 0; line_cnt = 0; line_rdy = 0;
        endfunction

        function void note_byte(logic [7:0] c);
            logic [1:0] ch[$];
            logic [7:0] by[$];
            logic [1:0] wreq;
            logic [1:0] ev;
            beat_t b;
            wreq = clp_pkg::WREQ_NONE;
            ev = 0;
            if (dbg_on) begin
                if (dbg_cnt < clp_pkg::DEBUG_FRAME_LEN) dbg_buf[dbg_cnt] = c;
                dbg_cnt++;
                if (dbg_cnt == 2) begin
                    if (dbg_buf[1] != clp_pkg::BYTE_SYNC_B) begin
                        wx_on = 1; wx_buf[0] = dbg_buf[1]; wx_cnt = 1; dbg_on = 0;
                    end
                end else if (dbg_cnt >= clp_pkg::DEBUG_FRAME_LEN) begin
                    if (dbg_buf[0] == clp_pkg::BYTE_SYNC_A &&
                        dbg_buf[1] == clp_pkg::BYTE_SYNC_B &&
                        dbg_buf[2] == clp_pkg::BYTE_DEBUG &&
                        dbg_buf[clp_pkg::DEBUG_FRAME_LEN-2] == clp_pkg::BYTE_SYNC_B &&
                        dbg_buf[clp_pkg::DEBUG_FRAME_LEN-1] == clp_pkg::BYTE_SYNC_A)
                        for (int k = 0; k < clp_pkg::DEBUG_FRAME_LEN; k++) begin
                            ch.push_back(clp_pkg::CHAN_VOICE); by.push_back(dbg_buf[k]);
                        end
                    dbg_on = 0; dbg_cnt = 0;
                end
            end else if (c == clp_pkg::BYTE_SYNC_A) begin
                dbg_on = 1; dbg_buf[0] = c; dbg_cnt = 1;
            end else if (wx_on) begin
                if (wx_cnt < clp_pkg::WEATHER_FRAME_LEN) wx_buf[wx_cnt] = c;
                wx_cnt++;
                if (wx_cnt >= clp_pkg::WEATHER_FRAME_LEN) begin
                    if (wx_buf[clp_pkg::WEATHER_FRAME_LEN-1] == clp_pkg::BYTE_SYNC_B) begin
                        for (int k = 0; k < 6; k++) wx_latch[8*k +: 8] = wx_buf[k];
                        mbits[2] = 1; ev[0] = 1;
                        by = '{clp_pkg::BYTE_SYNC_A, clp_pkg::BYTE_SYNC_B,
                               clp_pkg::BYTE_DEBUG, wx_latch[7:0],
                               wx_latch[15:8], wx_latch[23:16], wx_latch[39:32],
                               wx_latch[47:40], 8'h00, 8'h00,
                               clp_pkg::BYTE_SYNC_B, clp_pkg::BYTE_SYNC_A};
                        for (int k = 0; k < 12; k++) ch.push_back(clp_pkg::CHAN_VOICE);
                    end
                    wx_on = 0; wx_cnt = 0;
                end
            end else begin
                mbits[3] = 1;
                ch.push_back(clp_pkg::CHAN_ECHO); by.push_back(c);
                if (c == clp_pkg::CMD_WEATHER) begin
                    mbits[2] = ~mbits[2];
                    if (mbits[2]) ev[0] = 1;
                end else begin
                    mbits[2] = 0;
                    case (c)
                        clp_pkg::CMD_ACT_0: begin face = 0; action = 0; end
                        clp_pkg::CMD_ACT_1: begin face = 5; action = 1; end
                        clp_pkg::CMD_ACT_2: begin face = 2; action = 2; end
                        clp_pkg::CMD_ACT_3: action = 3;
                        clp_pkg::CMD_ACT_4: begin face = 4; action = 4; end
                        clp_pkg::CMD_ACT_5: begin face = 1; action = 5; end
                        clp_pkg::CMD_ACT_6: action = 6;
                        clp_pkg::CMD_ACT_7: action = 7;
                        clp_pkg::CMD_ACT_8: action = 8;
                        clp_pkg::CMD_SPEED: speed = (speed == clp_pkg::SPEED_MIN) ?
                            clp_pkg::SPEED_MAX : (speed > clp_pkg::SPEED_FLOOR) ?
                            speed - clp_pkg::SPEED_STEP : clp_pkg::SPEED_MAX;
                        clp_pkg::CMD_SWING: swing = (swing == clp_pkg::SWING_MIN) ?
                            clp_pkg::SWING_MAX : (swing > clp_pkg::SWING_FLOOR) ?
                            swing - 4'd1 : clp_pkg::SWING_MAX;
                        clp_pkg::CMD_TAIL: begin face = 4; mbits[0] = ~mbits[0]; end
                        clp_pkg::CMD_ACT_10: action = 10;
                        clp_pkg::CMD_ACT_11: action = 11;
                        clp_pkg::CMD_ACT_13: begin face = 6; action = 13; end
                        clp_pkg::CMD_ACT_14: begin face = 1; action = 14; end
                        clp_pkg::CMD_ACT_15: action = 15;
                        clp_pkg::CMD_DISPLAY: mbits[1] = ~mbits[1];
                        clp_pkg::CMD_ACTIVE: wreq = clp_pkg::WREQ_ACTIVE;
                        clp_pkg::CMD_QUIET: wreq = clp_pkg::WREQ_QUIET;
                        clp_pkg::CMD_SAVE: wreq = clp_pkg::WREQ_SAVE;
                        default: ;
                    endcase
                end
                ev[1] = 1;
                if (line_cnt < clp_pkg::LINE_LIMIT) begin
                    line_cnt++;
                    if (c == clp_pkg::CHAR_LF || c == clp_pkg::CHAR_CR) line_rdy = 1;
                end
            end
            if (ch.size() == 0) begin
                ch.push_back(clp_pkg::CHAN_NONE); by.push_back(8'h00);
            end
            foreach (ch[k]) begin
                b.chan = ch[k]; b.data = by[k]; b.fin = (k == ch.size() - 1);
                b.face = face; b.action = action; b.speed = speed; b.swing = swing;
                b.flg = {line_rdy, mbits}; b.wreq = wreq; b.ev = ev; b.wx = wx_latch;
                pending.push_back(b);
            end
        endfunction

        function void check_beat(beat_t a);
            beat_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat chan %0d byte %h", $time, a.chan, a.data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.chan !== e.chan) mism("tx_channel", e.chan, a.chan);
            if (a.data !== e.data) mism("tx_byte", e.data, a.data);
            if (a.fin !== e.fin) mism("last", e.fin, a.fin);
            if (a.face !== e.face) mism("face_sel", e.face, a.face);
            if (a.action !== e.action) mism("motion_sel", e.action, a.action);
            if (a.speed !== e.speed) mism("speed_delay", e.speed, a.speed);
            if (a.swing !== e.swing) mism("swing_delay", e.swing, a.swing);
            if (a.flg !== e.flg) mism("flags", e.flg, a.flg);
            if (a.wreq !== e.wreq) mism("work_mode_request", e.wreq, a.wreq);
            if (a.ev !== e.ev) mism("events", e.ev, a.ev);
            if (a.wx !== e.wx) mism("weather_record", e.wx, a.wx);
        endfunction

        function void mism(string name, logic [47:0] e, logic [47:0] a);
            $display("%0t: %s expected %h actual %h", $time, name, e, a);
            errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  rx_byte = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [1:0]  tx_channel;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  face_sel;
    logic [3:0]  motion_sel;
    logic [7:0]  speed_delay;
    logic [3:0]  swing_delay;
    logic [4:0]  flags;
    logic [1:0]  work_mode_request;
    logic [1:0]  events;
    logic [47:0] weather_record;

    frame_scoreboard sb = new();
    logic [7:0] stim[$];
    bit stim_done = 0;

    command_link_frame_parser uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        beat_t a;
        if (rst_n && out_valid && out_ready) begin
            a.chan = tx_channel; a.data = tx_byte; a.fin = last; a.face = face_sel;
            a.action = motion_sel; a.speed = speed_delay; a.swing = swing_delay;
            a.flg = flags; a.wreq = work_mode_request; a.ev = events;
            a.wx = weather_record;
            sb.check_beat(a);
        end
    end

    // receiver stall pattern
    int rcv_phase = 0;
    always @(posedge clk)
    begin
        rcv_phase <= rcv_phase + 1;
        if (rcv_phase % 700 < 200) out_ready <= 1'b1;
        else if (rcv_phase % 37 < 9) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_byte(logic [7:0] c);
        in_valid <= 1'b1;
        rx_byte <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(c);
    endtask

    task automatic run_stim();
        int gap;
        int burst;
        burst = 0;
        while (stim.size() > 0) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 20);
            end
            send_byte(stim.pop_front());
            burst--;
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_weather(bit good);
        stim.push_back(clp_pkg::BYTE_SYNC_A);
        stim.push_back(clp_pkg::BYTE_SYNC_B ^ 8'($urandom_range(1, 255)));
        repeat (6) stim.push_back(8'($urandom_range(0, 255)));
        stim.push_back(good ? clp_pkg::BYTE_SYNC_B : 8'($urandom_range(0, 255)));
    endtask

    task automatic add_debug(bit good);
        stim.push_back(clp_pkg::BYTE_SYNC_A);
        stim.push_back(clp_pkg::BYTE_SYNC_B);
        stim.push_back(good ? clp_pkg::BYTE_DEBUG : 8'($urandom_range(0, 255)));
        repeat (7) stim.push_back(8'($urandom_range(0, 255)));
        stim.push_back(good ? clp_pkg::BYTE_SYNC_B : 8'($urandom_range(0, 255)));
        stim.push_back(good ? clp_pkg::BYTE_SYNC_A : 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stim = '{8'h00, 8'hFF, clp_pkg::CMD_WEATHER, clp_pkg::CMD_WEATHER,
                 clp_pkg::CMD_SPEED, clp_pkg::CMD_SPEED, clp_pkg::CMD_SPEED,
                 clp_pkg::CMD_SPEED, clp_pkg::CMD_SPEED, clp_pkg::CMD_SWING,
                 clp_pkg::CMD_TAIL, clp_pkg::CMD_DISPLAY, clp_pkg::CMD_ACTIVE,
                 clp_pkg::CMD_QUIET, clp_pkg::CMD_SAVE, clp_pkg::CMD_ACT_13,
                 clp_pkg::CHAR_LF, clp_pkg::CMD_ACT_0};
        add_weather(1);
        add_debug(1);
        // debug frame opened inside a weather frame
        stim.push_back(clp_pkg::BYTE_SYNC_A); stim.push_back(8'h12); stim.push_back(8'h34);
        add_debug(1);
        repeat (5) stim.push_back(8'h55);
        run_stim();
        while (sb.pending.size() != 0) @(posedge clk);
        n = 0;
        while (n < 400) begin
            case ($urandom_range(0, 9))
                0, 1: begin add_weather($urandom_range(0, 3) != 0); n += 9; end
                2: begin add_debug($urandom_range(0, 2) != 0); n += 12; end
                3: begin stim.push_back(8'($urandom_range(8'h60, 8'h62))); n++; end
                4: begin stim.push_back(8'($urandom_range(0, 255))); n++; end
                5: begin
                    stim.push_back($urandom_range(0, 1) ? clp_pkg::CHAR_CR : clp_pkg::CHAR_LF);
                    n++;
                end
                default: begin stim.push_back(8'($urandom_range(8'h29, 8'h49))); n++; end
            endcase
            if (n > 200 && n < 230) begin
                run_stim();
                while (sb.pending.size() != 0) @(posedge clk);
                n = 230;
            end
        end
        run_stim();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
